// File: rtl/trcd_pkg.sv
// ----------------------------------------------------------------------------
// trcd_pkg: shared types and constants of the thruster ramp command decoder
// Holds the item payload structs, the sequencer states, channel codes and the
// thruster pulse level function.
// ----------------------------------------------------------------------------
package trcd_pkg;

	localparam int unsigned SETTING_W = 8;
	localparam int unsigned LEVEL_W   = 17;
	localparam int unsigned PWM_W     = 5;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [SETTING_W-1:0] NEUTRAL     = 8'd127;
	localparam logic [SETTING_W-1:0] TOP_SETTING = 8'd254;
	localparam logic [SETTING_W-1:0] MAX_VALUE   = 8'd255;

	// request kinds
	localparam logic REQ_CMD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// command channels
	localparam logic [7:0] CH_LED0    = 8'd6;
	localparam logic [7:0] CH_LED1    = 8'd7;
	localparam logic [7:0] CH_MOTOR0  = 8'd8;
	localparam logic [7:0] CH_MOTOR1  = 8'd9;
	localparam logic [7:0] CH_SERVO0  = 8'd10;
	localparam logic [7:0] CH_SERVO3  = 8'd13;
	localparam logic [7:0] CH_STATUS  = 8'd255;

	// output pins
	localparam logic [PWM_W-1:0] PIN_MOTOR_BASE = 5'd8;
	localparam logic [PWM_W-1:0] PIN_SERVO_OFS  = 5'd2;
	localparam logic [PWM_W-1:0] PIN_STATUS     = 5'd16;

	localparam logic [LEVEL_W-1:0] SERVO_SCALE = 17'd500;
	localparam logic [LEVEL_W-1:0] LEVEL_BASE  = 17'd500;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 4'd1;

	localparam logic [7:0]  RAMP_STEP_RST = 8'd1;
	localparam logic [15:0] TIMEOUT_RST   = 16'd500;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

	typedef struct packed {
		logic       req_type;
		logic [7:0] channel;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [PWM_W-1:0]   pwm_channel;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD_A,
		ST_CMD_B,
		ST_RAMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [SETTING_W-1:0] next_setting;
		logic                 moved;
	} ramp_res_t;

	// 250 + floor(250*(cur+127)/127) = 500 + 2*cur - ceil(4*cur/127)
	function automatic logic [LEVEL_W-1:0] thruster_level(input logic [SETTING_W-1:0] cur);
		logic [9:0] quad;
		logic [3:0] ceil_q;
		quad   = {cur, 2'b00};
		ceil_q = '0;
		for (int k = 0; k < 8; k++) begin
			if (quad > 10'(127 * k))
				ceil_q = ceil_q + 4'd1;
		end
		return LEVEL_BASE + {8'd0, cur, 1'b0} - {13'd0, ceil_q};
	endfunction

endpackage

// File: rtl/trcd_ramp_unit.sv
// ----------------------------------------------------------------------------
// trcd_ramp_unit: shared slew step for one thruster
// Moves a setting toward its target by at most the ramp step, clamped to
// 0..254, and flags whether the setting changed.
// ----------------------------------------------------------------------------
module trcd_ramp_unit (
	input  logic [7:0]         cur,
	input  logic [7:0]         tgt,
	input  logic [7:0]         step,
	output trcd_pkg::ramp_res_t res
);

	logic       up;
	logic [7:0] mag;
	logic [8:0] sum;
	logic [7:0] nc;

	always_comb begin
		up  = tgt > cur;
		mag = up ? (tgt - cur) : (cur - tgt);
		sum = {1'b0, cur} + {1'b0, step};
		if (cur == tgt) begin
			nc = cur;
		end else if (mag > step) begin
			if (up) begin
				nc = (sum > {1'b0, trcd_pkg::TOP_SETTING}) ? trcd_pkg::TOP_SETTING : sum[7:0];
			end else begin
				nc = (cur < step) ? 8'd0 : (cur - step);
			end
		end else begin
			nc = tgt;
		end
		res.next_setting = nc;
		res.moved        = nc != cur;
	end

endmodule

// File: rtl/trcd_out_reg.sv
// ----------------------------------------------------------------------------
// trcd_out_reg: result output register
// Holds one result item until the consumer takes it; accepts a new one in the
// same cycle the held item leaves.
// ----------------------------------------------------------------------------
module trcd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  trcd_pkg::rsp_t   push_data,
	output logic             can_push,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output trcd_pkg::rsp_t   rsp
);

	logic           valid_q;
	trcd_pkg::rsp_t data_q;

	assign can_push  = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_push) begin
			data_q <= push_data;
		end
	end

endmodule

// File: rtl/thruster_ramp_command_decoder.sv
// ----------------------------------------------------------------------------
// thruster_ramp_command_decoder: slew-rate limited thruster commands
// Decodes bus commands into output levels, ramps thruster settings toward
// their targets on control ticks and returns targets to neutral when no
// command has arrived for too long.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_valid/req_ready  | req_type, channel, value
//  rsp     | rsp_valid/rsp_ready  | pwm_channel, level, last
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
//  A command is accepted, then pushes its results (0, 1 or 2) in order.
//  A tick is accepted, then one ramp unit walks the thrusters one per cycle,
//  then a second pass walks them again up to the last changed one and emits
//  each changed one, one per cycle.
//  A stalled consumer holds the emit pass; req_ready is low until the item's
//  last result sits in the output register.
//  Reset sets targets and settings to neutral 127 and clears the idle count.
//
module thruster_ramp_command_decoder #(
	parameter int NUM_THRUSTERS = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  trcd_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output trcd_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [trcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [trcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = (NUM_THRUSTERS > 1) ? $clog2(NUM_THRUSTERS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_THRUSTERS - 1);

	// configuration
	logic [7:0]  ramp_step_q;
	logic [15:0] timeout_q;

	// thruster state
	logic [7:0]  tgt_q [NUM_THRUSTERS];
	logic [7:0]  cur_q [NUM_THRUSTERS];
	logic [NUM_THRUSTERS-1:0] chg_q;
	logic [15:0] idle_q;

	// sequencer
	trcd_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       cmd_chan_q;
	logic [7:0]       cmd_val_q;

	logic                  accept;
	logic                  push;
	logic                  can_push;
	trcd_pkg::rsp_t        push_data;
	logic                  idx_step;
	trcd_pkg::ramp_res_t   ramp_res;
	logic [15:0]           idle_inc;
	logic                  wd_fire;
	logic                  is_thruster;
	logic                  has_result;
	logic [NUM_THRUSTERS-1:0] chg_above;
	logic                  none_above;

	assign req_ready = state_q == trcd_pkg::ST_IDLE;
	assign accept    = req_valid && req_ready;

	// watchdog: saturating idle count, fire once it passes the limit
	assign idle_inc = (idle_q == trcd_pkg::IDLE_MAX) ? idle_q : (idle_q + 16'd1);
	assign wd_fire  = idle_inc > timeout_q;

	assign is_thruster = req.channel < 8'(NUM_THRUSTERS);
	assign has_result  = !is_thruster && (
		req.channel == trcd_pkg::CH_LED0 || req.channel == trcd_pkg::CH_LED1 ||
		req.channel == trcd_pkg::CH_MOTOR0 || req.channel == trcd_pkg::CH_MOTOR1 ||
		(req.channel >= trcd_pkg::CH_SERVO0 && req.channel <= trcd_pkg::CH_SERVO3) ||
		req.channel == trcd_pkg::CH_STATUS);

	// one ramp unit, shared by all thrusters through the walk index
	trcd_ramp_unit u_ramp (
		.cur  (cur_q[idx_q]),
		.tgt  (tgt_q[idx_q]),
		.step (ramp_step_q),
		.res  (ramp_res)
	);

	// changed thrusters still waiting beyond the current index
	always_comb begin
		for (int j = 0; j < NUM_THRUSTERS; j++) begin
			chg_above[j] = chg_q[j] && (IDX_W'(j) > idx_q);
		end
		none_above = ~|chg_above;
	end

	// next state and result selection
	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_data = '0;
		idx_step  = 1'b0;
		unique case (state_q)
			trcd_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.req_type == trcd_pkg::REQ_TICK) begin
						state_d = trcd_pkg::ST_RAMP;
					end else if (has_result) begin
						state_d = trcd_pkg::ST_CMD_A;
					end
				end
			end
			trcd_pkg::ST_CMD_A: begin
				push = 1'b1;
				push_data.last = 1'b1;
				if (cmd_chan_q == trcd_pkg::CH_MOTOR0 || cmd_chan_q == trcd_pkg::CH_MOTOR1) begin
					// pin A carries the value, pin B follows with zero
					push_data.pwm_channel = trcd_pkg::PIN_MOTOR_BASE + {3'd0, cmd_chan_q[0], 1'b0};
					push_data.level       = {9'd0, cmd_val_q};
					push_data.last        = 1'b0;
				end else if (cmd_chan_q == trcd_pkg::CH_STATUS) begin
					push_data.pwm_channel = trcd_pkg::PIN_STATUS;
					push_data.level       = {16'd0, |cmd_val_q};
				end else if (cmd_chan_q >= trcd_pkg::CH_SERVO0) begin
					push_data.pwm_channel = cmd_chan_q[4:0] + trcd_pkg::PIN_SERVO_OFS;
					push_data.level       = {9'd0, cmd_val_q} * trcd_pkg::SERVO_SCALE;
				end else begin
					push_data.pwm_channel = cmd_chan_q[4:0];
					push_data.level       = {9'd0, cmd_val_q};
				end
				if (can_push) begin
					state_d = push_data.last ? trcd_pkg::ST_IDLE : trcd_pkg::ST_CMD_B;
				end
			end
			trcd_pkg::ST_CMD_B: begin
				push                  = 1'b1;
				push_data.pwm_channel = trcd_pkg::PIN_MOTOR_BASE + {3'd0, cmd_chan_q[0], 1'b1};
				push_data.level       = '0;
				push_data.last        = 1'b1;
				if (can_push) begin
					state_d = trcd_pkg::ST_IDLE;
				end
			end
			trcd_pkg::ST_RAMP: begin
				// advance one thruster per cycle through the ramp unit
				idx_step = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = trcd_pkg::ST_EMIT;
				end
			end
			trcd_pkg::ST_EMIT: begin
				push_data.pwm_channel = 5'(idx_q);
				push_data.level       = trcd_pkg::thruster_level(cur_q[idx_q]);
				push_data.last        = none_above;
				if (chg_q[idx_q]) begin
					push = 1'b1;
					if (can_push) begin
						idx_step = 1'b1;
						if (none_above) state_d = trcd_pkg::ST_IDLE;
					end
				end else begin
					// skip unchanged thrusters; drop out when nothing is left
					idx_step = 1'b1;
					if (none_above) state_d = trcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = trcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk index: restart at each tick, wrap after the last thruster
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept || state_d == trcd_pkg::ST_IDLE) begin
			idx_q <= '0;
		end else if (idx_step) begin
			idx_q <= (idx_q == IDX_LAST) ? '0 : (idx_q + IDX_W'(1));
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= trcd_pkg::RAMP_STEP_RST;
			timeout_q   <= trcd_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == trcd_pkg::REG_RAMP_STEP) begin
				ramp_step_q <= cfg_data[7:0];
			end else if (cfg_index == trcd_pkg::REG_TIMEOUT_TICKS) begin
				timeout_q <= cfg_data;
			end
		end
	end

	// targets, settings, change flags and the idle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THRUSTERS; i++) begin
				tgt_q[i] <= trcd_pkg::NEUTRAL;
				cur_q[i] <= trcd_pkg::NEUTRAL;
			end
			chg_q  <= '0;
			idle_q <= '0;
		end else begin
			if (accept) begin
				if (req.req_type == trcd_pkg::REQ_CMD) begin
					idle_q <= '0;
					if (is_thruster) begin
						// hold a full-scale target to the top setting
						tgt_q[req.channel[IDX_W-1:0]] <= (req.value == trcd_pkg::MAX_VALUE) ?
							trcd_pkg::TOP_SETTING : req.value;
					end
				end else begin
					chg_q <= '0;
					if (wd_fire) begin
						idle_q <= '0;
						for (int i = 0; i < NUM_THRUSTERS; i++) begin
							tgt_q[i] <= trcd_pkg::NEUTRAL;
						end
					end else begin
						idle_q <= idle_inc;
					end
				end
			end
			if (state_q == trcd_pkg::ST_RAMP) begin
				cur_q[idx_q] <= ramp_res.next_setting;
				chg_q[idx_q] <= ramp_res.moved;
			end
		end
	end

	// command payload held for the result cycles
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_chan_q <= req.channel;
			cmd_val_q  <= req.value;
		end
	end

	trcd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: verif/thruster_ramp_command_decoder_test.sv
// ----------------------------------------------------------------------------
// thruster_ramp_command_decoder_test: self-checking bench for the decoder
// Sends bus commands and control ticks through the request channel. A local
// predictor keeps its own targets, settings, idle count and registers, and
// builds the expected pulse levels for every accepted item. Each returned
// level is checked field by field against the oldest expected one. Both
// sides idle and stall at random across several register settings.
// ----------------------------------------------------------------------------
module thruster_ramp_command_decoder_test;

	localparam int THRUSTERS   = 6;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 73;
	// a tick walks the thrusters twice; leave margin on top of that
	localparam int QUIET_CYCLES = 2 * THRUSTERS + 8;
	localparam int LONG_HOLD    = 300;
	localparam int RUN_LIMIT    = 2000000;

	// indexes past the register list; the block must ignore writes there
	localparam logic [trcd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
	localparam logic [trcd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

	class pwm_level_book;

		trcd_pkg::rsp_t levels_due[$];
		trcd_pkg::rsp_t batch[$];
		logic [7:0]     target_of[THRUSTERS];
		logic [7:0]     setting_of[THRUSTERS];
		logic [15:0]    idle_ticks;
		logic [7:0]     step_reg;
		logic [15:0]    timeout_reg;
		int             errors;

		function new();
			for (int i = 0; i < THRUSTERS; i++) begin
				target_of[i]  = trcd_pkg::NEUTRAL;
				setting_of[i] = trcd_pkg::NEUTRAL;
			end
			idle_ticks  = '0;
			step_reg    = trcd_pkg::RAMP_STEP_RST;
			timeout_reg = trcd_pkg::TIMEOUT_RST;
			errors      = 0;
		endfunction

		function int pending();
			return levels_due.size();
		endfunction

		function void write_reg(logic [trcd_pkg::CFG_IDX_W-1:0] idx,
			logic [trcd_pkg::CFG_DATA_W-1:0] data);
			if (idx == trcd_pkg::REG_RAMP_STEP)
				step_reg = data[7:0];
			else if (idx == trcd_pkg::REG_TIMEOUT_TICKS)
				timeout_reg = data;
		endfunction

		function void emit(int pin, int lvl);
			trcd_pkg::rsp_t one;
			one.pwm_channel = pin[trcd_pkg::PWM_W-1:0];
			one.level       = lvl[trcd_pkg::LEVEL_W-1:0];
			one.last        = 1'b0;
			batch.push_back(one);
		endfunction

		function void take_request(trcd_pkg::req_t r);
			trcd_pkg::rsp_t tail;
			int   d;
			int   mag;
			int   cur;
			int   nc;
			if (r.req_type == trcd_pkg::REQ_CMD) begin
				idle_ticks = '0;
				if (r.channel < THRUSTERS)
					target_of[r.channel] = (r.value == trcd_pkg::MAX_VALUE) ?
						trcd_pkg::TOP_SETTING : r.value;
				else if (r.channel == trcd_pkg::CH_LED0 || r.channel == trcd_pkg::CH_LED1)
					emit(r.channel, r.value);
				else if (r.channel == trcd_pkg::CH_MOTOR0 ||
					r.channel == trcd_pkg::CH_MOTOR1) begin
					emit(8 + 2 * (r.channel - trcd_pkg::CH_MOTOR0), r.value);
					emit(9 + 2 * (r.channel - trcd_pkg::CH_MOTOR0), 0);
				end else if (r.channel >= trcd_pkg::CH_SERVO0 &&
					r.channel <= trcd_pkg::CH_SERVO3)
					emit(r.channel + 2, 500 * r.value);
				else if (r.channel == trcd_pkg::CH_STATUS)
					emit(16, (r.value != 0) ? 1 : 0);
			end else begin
				if (idle_ticks != 16'hFFFF)
					idle_ticks = idle_ticks + 16'd1;
				if (idle_ticks > timeout_reg) begin
					for (int i = 0; i < THRUSTERS; i++)
						target_of[i] = trcd_pkg::NEUTRAL;
					idle_ticks = '0;
				end
				for (int i = 0; i < THRUSTERS; i++) begin
					cur = setting_of[i];
					d   = int'(target_of[i]) - cur;
					mag = (d < 0) ? -d : d;
					if (d == 0)
						continue;
					if (mag > int'(step_reg)) begin
						nc = (d > 0) ? cur + step_reg : cur - step_reg;
						if (nc > 254)
							nc = 254;
						if (nc < 0)
							nc = 0;
					end else begin
						nc = target_of[i];
					end
					if (nc == cur)
						continue;
					setting_of[i] = 8'(nc);
					emit(i, 250 + (250 * (nc + 127)) / 127);
				end
			end
			if (batch.size() > 0) begin
				tail = batch.pop_back();
				tail.last = 1'b1;
				batch.push_back(tail);
				while (batch.size() > 0)
					levels_due.push_back(batch.pop_front());
			end
		endfunction

		function void check_level(trcd_pkg::rsp_t got);
			trcd_pkg::rsp_t want;
			if (levels_due.size() == 0) begin
				$error("unexpected result: pwm_channel %0d level %0d last %0b",
					got.pwm_channel, got.level, got.last);
				errors++;
				return;
			end
			want = levels_due.pop_front();
			if (got.pwm_channel !== want.pwm_channel) begin
				$error("pwm_channel: expected %0d, got %0d", want.pwm_channel, got.pwm_channel);
				errors++;
			end
			if (got.level !== want.level) begin
				$error("level: expected %0d, got %0d", want.level, got.level);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction

	endclass

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_ready;
	trcd_pkg::req_t                  req       = '0;
	logic                            rsp_valid;
	logic                            rsp_ready = 1'b0;
	trcd_pkg::rsp_t                  rsp;
	logic                            cfg_we    = 1'b0;
	logic [trcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [trcd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	pwm_level_book level_book = new();

	// sender bookkeeping
	int   burst_left   = 0;
	int   useful_items = 0;
	bit   no_gaps      = 1'b0;
	// raised by the stimulus, consumed by the sink process
	bit   hold_sink    = 1'b0;

	thruster_ramp_command_decoder #(
		.NUM_THRUSTERS(THRUSTERS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample both handshakes on the edge. Check the result before noting a
	// new item so a stray result never matches an item taken on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				level_book.check_level(rsp);
			if (req_valid && req_ready)
				level_book.take_request(req);
		end
	end

	// Result sink: stalls on a pattern of random stretches, and on request
	// holds off for a long fixed run so the block backs up into its input.
	initial begin : pwm_sink
		sink_mode_t mode;
		int         stretch_left;
		int         hold_left;
		mode         = SINK_OPEN;
		stretch_left = 0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_sink) begin
				hold_sink = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode         = sink_mode_t'($urandom_range(SINK_OPEN, SINK_PERIODIC));
					stretch_left = $urandom_range(8, 64);
				end
				stretch_left--;
				case (mode)
					SINK_OPEN: begin
						rsp_ready <= 1'b1;
					end
					SINK_COIN: begin
						rsp_ready <= 1'($urandom_range(0, 1));
					end
					SINK_SPARSE: begin
						rsp_ready <= ($urandom_range(0, 5) == 0);
					end
					default: begin
						rsp_ready <= (stretch_left % 3 == 0);
					end
				endcase
			end
		end
	end

	function automatic trcd_pkg::req_t compose_req(input logic kind, input logic [7:0] ch,
		input logic [7:0] val);
		trcd_pkg::req_t r;
		r.req_type = kind;
		r.channel  = ch;
		r.value    = val;
		return r;
	endfunction

	// Offer one item and hold it until accepted. Bursts of random length are
	// separated by random gaps; valid drops only when a gap really follows.
	task automatic push_item(input trcd_pkg::req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		// unknown channels only clear the idle count; do not count them
		if (!(item.req_type == trcd_pkg::REQ_CMD && item.channel > trcd_pkg::CH_SERVO3 &&
			item.channel != trcd_pkg::CH_STATUS))
			useful_items++;
	endtask

	// Stop offering, let every expected level come back, then give a silent
	// tick time to finish its walk before anything touches the registers.
	task automatic drain_block();
		req_valid  <= 1'b0;
		burst_left = 0;
		// let the edge pass so the item taken on it is already noted
		@(posedge clk);
		while (level_book.pending() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller drops it after its last write.
	task automatic write_reg(input logic [trcd_pkg::CFG_IDX_W-1:0] idx,
		input logic [trcd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		level_book.write_reg(idx, data);
	endtask

	// One random chunk: mostly thruster targets and runs of ticks so the
	// ramps and the watchdog get exercised, some peripheral writes, some noise.
	task automatic run_random_sequence();
		int         pick;
		int         n;
		int         k;
		logic [7:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(0, 7))
					0:       val = trcd_pkg::MAX_VALUE;
					1:       val = 8'd0;
					2:       val = trcd_pkg::NEUTRAL;
					default: val = 8'($urandom);
				endcase
				push_item(compose_req(trcd_pkg::REQ_CMD,
					8'($urandom_range(0, THRUSTERS - 1)), val));
			end
		end else if (pick < 65) begin
			n = $urandom_range(1, 14);
			repeat (n)
				push_item(compose_req(trcd_pkg::REQ_TICK, 8'($urandom), 8'($urandom)));
		end else if (pick < 88) begin
			k = $urandom_range(trcd_pkg::CH_LED0, trcd_pkg::CH_SERVO3 + 1);
			push_item(compose_req(trcd_pkg::REQ_CMD,
				(k > trcd_pkg::CH_SERVO3) ? trcd_pkg::CH_STATUS : 8'(k),
				8'($urandom)));
		end else begin
			push_item(compose_req(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom)));
		end
	endtask

	// Hard stop in case the block hangs.
	initial begin : run_limit
		#(RUN_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  step_now;
		logic [15:0] wait_now;
		int          phase_end;

		// hold reset low from the start, then release on an edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-range step so a single tick reaches the extremes, short watchdog;
		// writes to indexes past the list must change nothing.
		write_reg(trcd_pkg::REG_RAMP_STEP, 16'd254);
		write_reg(trcd_pkg::REG_TIMEOUT_TICKS, 16'd3);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0000);
		cfg_we <= 1'b0;

		// thruster targets: 255 is held to 254, 0 is the low end; no results yet
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd0, trcd_pkg::MAX_VALUE));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd1, 8'd0));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd2, 8'd200));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd5, 8'd128));
		// first tick moves all four, the second finds nothing to move
		push_item(compose_req(trcd_pkg::REQ_TICK, 8'd0, 8'd0));
		push_item(compose_req(trcd_pkg::REQ_TICK, 8'hFF, 8'hFF));
		// every peripheral kind, including value extremes
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_LED0, 8'd0));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_LED1, 8'd255));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_MOTOR0, 8'd255));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_MOTOR1, 8'd1));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_SERVO0, 8'd255));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd11, 8'd1));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd12, 8'd128));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_SERVO3, 8'd0));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_STATUS, 8'd0));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_STATUS, 8'd1));
		push_item(compose_req(trcd_pkg::REQ_CMD, trcd_pkg::CH_STATUS, 8'd255));
		// unknown channels: silent, but they still clear the idle count
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd14, 8'd55));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd254, 8'd170));
		push_item(compose_req(trcd_pkg::REQ_CMD, 8'd100, 8'd255));
		// three quiet ticks, then the watchdog fires and everything returns
		repeat (4)
			push_item(compose_req(trcd_pkg::REQ_TICK, 8'($urandom), 8'($urandom)));

		for (int p = 0; p < PHASES; p++) begin
			// every phase starts from a drained block, which doubles as the
			// pause that waits for all outstanding levels
			drain_block();
			case (p)
				0: begin
					step_now = trcd_pkg::RAMP_STEP_RST;
					wait_now = trcd_pkg::TIMEOUT_RST;
				end
				1: begin
					// zero step: nothing farther than zero away ever moves
					step_now = 8'd0;
					wait_now = 16'd10;
				end
				2: begin
					// watchdog disabled
					step_now = 8'd254;
					wait_now = 16'hFFFF;
				end
				3: begin
					// watchdog fires on every tick
					step_now = 8'd3;
					wait_now = 16'd0;
				end
				4: begin
					step_now = 8'd37;
					wait_now = 16'd5;
				end
				default: begin
					step_now = 8'($urandom_range(1, 254));
					wait_now = 16'($urandom_range(0, 40));
				end
			endcase
			write_reg(trcd_pkg::REG_RAMP_STEP, {8'd0, step_now});
			write_reg(trcd_pkg::REG_TIMEOUT_TICKS, wait_now);
			cfg_we <= 1'b0;

			// one phase offers back to back against a long sink hold-off
			no_gaps = (p == 2);
			if (p == 2)
				hold_sink = 1'b1;
			phase_end = useful_items + PHASE_ITEMS;
			while (useful_items < phase_end)
				run_random_sequence();
		end

		drain_block();
		if (level_book.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/trcd_pkg.sv
rtl/trcd_ramp_unit.sv
rtl/trcd_out_reg.sv
rtl/thruster_ramp_command_decoder.sv
verif/thruster_ramp_command_decoder_test.sv
